// ===== hdl/cfla_pkg.sv =====
// Shared types and constants for the coalescing free-list allocator.
// No dependencies; used by cfla_ram and coalescing_free_list_allocator.
package cfla_pkg;

  localparam int OFF_W           = 32;
  localparam int IDX_W           = 7;
  localparam int MAX_EXTENTS_DEF = 64;
  localparam logic [OFF_W-1:0] REGION_RESET = 32'd65536;

  typedef enum logic [1:0] {
    K_ALLOC_FRONT,
    K_ALLOC_BACK,
    K_FREE,
    K_INIT
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_INDEX,
    ST_BAD_SIZE,
    ST_BOUNDS,
    ST_OVERLAP,
    ST_FULL
  } status_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] len;
  } extent_t;

endpackage

// ===== hdl/coalescing_free_list_allocator.sv =====
// Coalescing free-list allocator: sequencer around an offset-sorted extent table.
// Depends on cfla_pkg and cfla_ram.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------
//   in       | in_valid / in_stall   | kind, entry_index, offset, size
//   out      | out_valid / out_stall | status, result_index, alloc_offset,
//            |                       | free_total, largest_free, entry_count
//   cfg      | cfg_valid / cfg_ready | region_size
//
// One transaction at a time; each steps through the states below before the next accept.
// Index, zero-size free and bounds errors and init go from decode straight to the
// result; size, overlap and full errors first read the neighbours from the table.
// Successful allocates and frees then scan all entries for the largest extent, after
// shifting entries down on a removal, or shifting entries up and then writing the new
// entry on an insertion.
// Reset is synchronous; the table itself is not cleared, the entry count is.
// A result held under out_stall blocks completion of the next transaction only.
module coalescing_free_list_allocator #(
  parameter int MAX_EXTENTS = cfla_pkg::MAX_EXTENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [cfla_pkg::IDX_W-1:0]    entry_index,
  input  logic [cfla_pkg::OFF_W-1:0]    offset,
  input  logic [cfla_pkg::OFF_W-1:0]    size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [cfla_pkg::IDX_W-1:0]    result_index,
  output logic [cfla_pkg::OFF_W-1:0]    alloc_offset,
  output logic [cfla_pkg::OFF_W-1:0]    free_total,
  output logic [cfla_pkg::OFF_W-1:0]    largest_free,
  output logic [cfla_pkg::IDX_W-1:0]    entry_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cfla_pkg::OFF_W-1:0]    region_size
);

  localparam int OW = cfla_pkg::OFF_W;
  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int XW = (CW > cfla_pkg::IDX_W) ? CW : cfla_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_CAPP, S_CAPC, S_EVAL, S_RM, S_INS, S_INSW, S_SCAN, S_FIN
  } state_t;

  state_t state, state_next;
  cfla_pkg::kind_t kind_q, kind_q_next;
  logic [XW-1:0] idx_q, idx_q_next;
  logic [OW-1:0] off_q, off_q_next, sz_q, sz_q_next;
  logic [OW-1:0] region, region_next;
  logic [CW-1:0] count, count_next;
  logic [OW-1:0] free_b, free_b_next, best, best_next;
  cfla_pkg::extent_t prev_e, prev_e_next, cur_e, cur_e_next;
  cfla_pkg::status_t st_q, st_q_next;
  logic [XW-1:0] res_q, res_q_next;
  logic [OW-1:0] alloc_q, alloc_q_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [CW-1:0] scan_ptr, scan_ptr_next;
  logic sc_pend, sc_pend_next;
  logic out_valid_next;
  logic [2:0] status_next;
  logic [cfla_pkg::IDX_W-1:0] result_index_next, entry_count_next;
  logic [OW-1:0] alloc_offset_next, free_total_next, largest_free_next;

  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  cfla_pkg::extent_t wr_data, rd_data;

  logic [XW-1:0] cnt_x;
  logic [AW-1:0] idx_a, idx_m1_a;
  logic [OW:0] end_w, prev_end;
  logic has_nxt, has_prv, ov, nxt, prv;

  cfla_ram #(.DEPTH(MAX_EXTENTS), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign cnt_x    = XW'(count);
  assign idx_a    = idx_q[AW-1:0];
  assign idx_m1_a = idx_a - AW'(1);
  assign end_w    = {1'b0, off_q} + {1'b0, sz_q};
  assign prev_end = {1'b0, prev_e.off} + {1'b0, prev_e.len};
  assign has_nxt  = idx_q < cnt_x;
  assign has_prv  = idx_q != '0;
  assign ov  = (has_nxt && end_w > {1'b0, cur_e.off}) || (has_prv && prev_end > {1'b0, off_q});
  assign nxt = has_nxt && ({1'b0, cur_e.off} == end_w);
  assign prv = has_prv && (prev_end == {1'b0, off_q});

  always_comb begin
    state_next        = state;
    kind_q_next       = kind_q;
    idx_q_next        = idx_q;
    off_q_next        = off_q;
    sz_q_next         = sz_q;
    region_next       = region;
    count_next        = count;
    free_b_next       = free_b;
    best_next         = best;
    prev_e_next       = prev_e;
    cur_e_next        = cur_e;
    st_q_next         = st_q;
    res_q_next        = res_q;
    alloc_q_next      = alloc_q;
    ptr_next          = ptr;
    scan_ptr_next     = scan_ptr;
    sc_pend_next      = sc_pend;
    out_valid_next    = out_valid;
    status_next       = status;
    result_index_next = result_index;
    alloc_offset_next = alloc_offset;
    free_total_next   = free_total;
    largest_free_next = largest_free;
    entry_count_next  = entry_count;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cur_e;
    rd_en   = 1'b0;
    rd_addr = '0;

    if (cfg_valid) begin
      region_next = region_size;
    end
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_q_next = cfla_pkg::kind_t'(kind);
          idx_q_next  = XW'(entry_index);
          off_q_next  = offset;
          sz_q_next   = size;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        res_q_next   = idx_q;
        alloc_q_next = '0;
        st_q_next    = cfla_pkg::ST_OK;
        state_next   = S_FIN;
        case (kind_q)
          cfla_pkg::K_ALLOC_FRONT, cfla_pkg::K_ALLOC_BACK: begin
            if (!has_nxt) begin
              st_q_next = cfla_pkg::ST_BAD_INDEX;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = idx_a;
              state_next = S_CAPC;
            end
          end
          cfla_pkg::K_FREE: begin
            if (idx_q > cnt_x) begin
              st_q_next = cfla_pkg::ST_BAD_INDEX;
            end else if (sz_q == '0) begin
              st_q_next = cfla_pkg::ST_BAD_SIZE;
            end else if (off_q >= region || end_w > {1'b0, region}) begin
              st_q_next = cfla_pkg::ST_BOUNDS;
            end else if (has_prv) begin
              rd_en      = 1'b1;
              rd_addr    = idx_m1_a;
              state_next = S_CAPP;
            end else if (has_nxt) begin
              rd_en      = 1'b1;
              rd_addr    = idx_a;
              state_next = S_CAPC;
            end else begin
              state_next = S_EVAL;
            end
          end
          default: begin
            if (region == '0) begin
              st_q_next = cfla_pkg::ST_BAD_SIZE;
            end else begin
              wr_en       = 1'b1;
              wr_addr     = '0;
              wr_data.off = '0;
              wr_data.len = region;
              count_next  = CW'(1);
              free_b_next = region;
              best_next   = region;
              res_q_next  = '0;
            end
          end
        endcase
      end
      S_CAPP: begin
        prev_e_next = rd_data;
        if (has_nxt) begin
          rd_en      = 1'b1;
          rd_addr    = idx_a;
          state_next = S_CAPC;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_CAPC: begin
        cur_e_next = rd_data;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        // default exit: rescan the table for the largest extent
        state_next    = S_SCAN;
        scan_ptr_next = '0;
        sc_pend_next  = 1'b0;
        best_next     = '0;
        if (kind_q != cfla_pkg::K_FREE) begin
          if (sz_q == '0 || sz_q > cur_e.len || sz_q > free_b) begin
            st_q_next  = cfla_pkg::ST_BAD_SIZE;
            best_next  = best;
            state_next = S_FIN;
          end else begin
            free_b_next = free_b - sz_q;
            if (kind_q == cfla_pkg::K_ALLOC_FRONT) begin
              alloc_q_next = cur_e.off;
            end else begin
              alloc_q_next = cur_e.off + cur_e.len - sz_q;
            end
            if (sz_q == cur_e.len) begin
              if (idx_q + XW'(1) < cnt_x) begin
                rd_en      = 1'b1;
                rd_addr    = idx_a + AW'(1);
                ptr_next   = idx_a + AW'(1);
                state_next = S_RM;
              end else begin
                count_next = count - CW'(1);
              end
            end else begin
              wr_en   = 1'b1;
              wr_addr = idx_a;
              wr_data.off = (kind_q == cfla_pkg::K_ALLOC_FRONT) ? cur_e.off + sz_q : cur_e.off;
              wr_data.len = cur_e.len - sz_q;
            end
          end
        end else if (ov) begin
          st_q_next  = cfla_pkg::ST_OVERLAP;
          best_next  = best;
          state_next = S_FIN;
        end else if (!nxt && !prv && count == CW'(MAX_EXTENTS)) begin
          st_q_next  = cfla_pkg::ST_FULL;
          best_next  = best;
          state_next = S_FIN;
        end else begin
          free_b_next = free_b + sz_q;
          if (nxt && prv) begin
            wr_en       = 1'b1;
            wr_addr     = idx_m1_a;
            wr_data.off = prev_e.off;
            wr_data.len = prev_e.len + sz_q + cur_e.len;
            // drop the absorbed next entry
            if (idx_q + XW'(1) < cnt_x) begin
              rd_en      = 1'b1;
              rd_addr    = idx_a + AW'(1);
              ptr_next   = idx_a + AW'(1);
              state_next = S_RM;
            end else begin
              count_next = count - CW'(1);
            end
          end else if (prv) begin
            wr_en       = 1'b1;
            wr_addr     = idx_m1_a;
            wr_data.off = prev_e.off;
            wr_data.len = prev_e.len + sz_q;
          end else if (nxt) begin
            wr_en       = 1'b1;
            wr_addr     = idx_a;
            wr_data.off = off_q;
            wr_data.len = cur_e.len + sz_q;
            res_q_next  = idx_q + XW'(1);
          end else if (cnt_x > idx_q) begin
            rd_en      = 1'b1;
            rd_addr    = AW'(count - CW'(1));
            ptr_next   = AW'(count - CW'(1));
            state_next = S_INS;
          end else begin
            wr_en       = 1'b1;
            wr_addr     = idx_a;
            wr_data.off = off_q;
            wr_data.len = sz_q;
            count_next  = count + CW'(1);
          end
        end
      end
      S_RM: begin
        // shift down: entry ptr moves to ptr-1
        wr_en   = 1'b1;
        wr_addr = ptr - AW'(1);
        wr_data = rd_data;
        if (CW'(ptr) + CW'(1) < count) begin
          rd_en    = 1'b1;
          rd_addr  = ptr + AW'(1);
          ptr_next = ptr + AW'(1);
        end else begin
          count_next    = count - CW'(1);
          scan_ptr_next = '0;
          sc_pend_next  = 1'b0;
          best_next     = '0;
          state_next    = S_SCAN;
        end
      end
      S_INS: begin
        // shift up: entry ptr moves to ptr+1
        wr_en   = 1'b1;
        wr_addr = ptr + AW'(1);
        wr_data = rd_data;
        if (XW'(ptr) > idx_q) begin
          rd_en    = 1'b1;
          rd_addr  = ptr - AW'(1);
          ptr_next = ptr - AW'(1);
        end else begin
          state_next = S_INSW;
        end
      end
      S_INSW: begin
        wr_en         = 1'b1;
        wr_addr       = idx_a;
        wr_data.off   = off_q;
        wr_data.len   = sz_q;
        count_next    = count + CW'(1);
        scan_ptr_next = '0;
        sc_pend_next  = 1'b0;
        best_next     = '0;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (sc_pend && rd_data.len > best) begin
          best_next = rd_data.len;
        end
        if (scan_ptr < count) begin
          rd_en         = 1'b1;
          rd_addr       = scan_ptr[AW-1:0];
          scan_ptr_next = scan_ptr + CW'(1);
          sc_pend_next  = 1'b1;
        end else begin
          sc_pend_next = 1'b0;
          if (!sc_pend) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          status_next       = st_q;
          result_index_next = res_q[cfla_pkg::IDX_W-1:0];
          alloc_offset_next = alloc_q;
          free_total_next   = free_b;
          largest_free_next = best;
          entry_count_next  = cfla_pkg::IDX_W'(count);
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      region    <= cfla_pkg::REGION_RESET;
      count     <= '0;
      free_b    <= '0;
      best      <= '0;
      sc_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      region    <= region_next;
      count     <= count_next;
      free_b    <= free_b_next;
      best      <= best_next;
      sc_pend   <= sc_pend_next;
      out_valid <= out_valid_next;
    end
    kind_q       <= kind_q_next;
    idx_q        <= idx_q_next;
    off_q        <= off_q_next;
    sz_q         <= sz_q_next;
    prev_e       <= prev_e_next;
    cur_e        <= cur_e_next;
    st_q         <= st_q_next;
    res_q        <= res_q_next;
    alloc_q      <= alloc_q_next;
    ptr          <= ptr_next;
    scan_ptr     <= scan_ptr_next;
    status       <= status_next;
    result_index <= result_index_next;
    alloc_offset <= alloc_offset_next;
    free_total   <= free_total_next;
    largest_free <= largest_free_next;
    entry_count  <= entry_count_next;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_EXTENTS))
    else $error("extent count above table depth");

  a_empty_largest: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && count == '0) |-> best == '0)
    else $error("largest extent nonzero with empty table");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state != S_IDLE && state != S_FIN && state != S_SCAN)
    else $error("table write outside an update step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rd_en) |-> scan_ptr < count)
    else $error("scan read beyond entry count");
`endif

endmodule

// ===== hdl/cfla_ram.sv =====
// Extent table storage: one write port, one read port, registered read data.
// Depends on cfla_pkg for the extent entry type.
module cfla_ram #(
  parameter int DEPTH = cfla_pkg::MAX_EXTENTS_DEF,
  parameter int AW    = $clog2(cfla_pkg::MAX_EXTENTS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  cfla_pkg::extent_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output cfla_pkg::extent_t rd_data
);

  cfla_pkg::extent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/sv/tb_coalescing_free_list_allocator.sv =====
// Self-checking testbench for coalescing_free_list_allocator.
// Depends on cfla_pkg and the allocator RTL; predicts each result from a
// shadow copy of the extent table.
module tb_coalescing_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEXT = cfla_pkg::MAX_EXTENTS_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    cfla_pkg::status_t              st;
    logic [cfla_pkg::IDX_W-1:0]     ridx;
    logic [cfla_pkg::OFF_W-1:0]     aoff;
    logic [cfla_pkg::OFF_W-1:0]     ftot;
    logic [cfla_pkg::OFF_W-1:0]     lfree;
    logic [cfla_pkg::IDX_W-1:0]     cnt;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [cfla_pkg::IDX_W-1:0] entry_index = '0;
  logic [cfla_pkg::OFF_W-1:0] offset = '0;
  logic [cfla_pkg::OFF_W-1:0] size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [cfla_pkg::IDX_W-1:0] result_index;
  logic [cfla_pkg::OFF_W-1:0] alloc_offset;
  logic [cfla_pkg::OFF_W-1:0] free_total;
  logic [cfla_pkg::OFF_W-1:0] largest_free;
  logic [cfla_pkg::IDX_W-1:0] entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cfla_pkg::OFF_W-1:0] region_size = cfla_pkg::REGION_RESET;

  coalescing_free_list_allocator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow state
  logic [cfla_pkg::OFF_W-1:0] sh_region = cfla_pkg::REGION_RESET;
  logic [cfla_pkg::OFF_W-1:0] sh_off[NEXT];
  logic [cfla_pkg::OFF_W-1:0] sh_len[NEXT];
  int unsigned                sh_cnt = 0;
  logic [cfla_pkg::OFF_W-1:0] sh_free = '0;

  alloc_result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic alloc_result_t predict_request(cfla_pkg::kind_t k, int unsigned idx,
                                                    logic [cfla_pkg::OFF_W-1:0] off,
                                                    logic [cfla_pkg::OFF_W-1:0] sz);
    alloc_result_t r;
    logic [cfla_pkg::OFF_W:0] fend;
    logic [cfla_pkg::OFF_W:0] pend;
    logic nxt, prv;
    logic [cfla_pkg::OFF_W-1:0] best;
    r.st = cfla_pkg::ST_OK;
    r.ridx = idx[cfla_pkg::IDX_W-1:0];
    r.aoff = '0;
    nxt = 1'b0;
    prv = 1'b0;
    pend = '0;
    fend = {1'b0, off} + {1'b0, sz};
    case (k)
      cfla_pkg::K_ALLOC_FRONT, cfla_pkg::K_ALLOC_BACK: begin
        if (idx >= sh_cnt) r.st = cfla_pkg::ST_BAD_INDEX;
        else if (sz == 0 || sz > sh_len[idx] || sz > sh_free) r.st = cfla_pkg::ST_BAD_SIZE;
        else begin
          sh_free -= sz;
          if (k == cfla_pkg::K_ALLOC_FRONT) begin
            r.aoff = sh_off[idx];
            sh_off[idx] = sh_off[idx] + sz;
          end else begin
            r.aoff = sh_off[idx] + sh_len[idx] - sz;
          end
          if (sz == sh_len[idx]) begin
            for (int i = idx; i + 1 < sh_cnt; i++) begin
              sh_off[i] = sh_off[i+1];
              sh_len[i] = sh_len[i+1];
            end
            sh_cnt--;
          end else sh_len[idx] -= sz;
        end
      end
      cfla_pkg::K_FREE: begin
        if (idx > 0 && idx <= sh_cnt)
          pend = {1'b0, sh_off[idx-1]} + {1'b0, sh_len[idx-1]};
        if (idx > sh_cnt) r.st = cfla_pkg::ST_BAD_INDEX;
        else if (sz == 0) r.st = cfla_pkg::ST_BAD_SIZE;
        else if (off >= sh_region || fend > {1'b0, sh_region}) r.st = cfla_pkg::ST_BOUNDS;
        else if ((idx < sh_cnt && fend > {1'b0, sh_off[idx]}) ||
                 (idx > 0 && pend > {1'b0, off})) r.st = cfla_pkg::ST_OVERLAP;
        else begin
          nxt = idx < sh_cnt && {1'b0, sh_off[idx]} == fend;
          prv = idx > 0 && pend == {1'b0, off};
          if (!nxt && !prv && sh_cnt >= NEXT) r.st = cfla_pkg::ST_FULL;
          else begin
            sh_free += sz;
            if (nxt && prv) begin
              sh_len[idx-1] += sz + sh_len[idx];
              for (int i = idx; i + 1 < sh_cnt; i++) begin
                sh_off[i] = sh_off[i+1];
                sh_len[i] = sh_len[i+1];
              end
              sh_cnt--;
            end else if (prv) sh_len[idx-1] += sz;
            else if (nxt) begin
              sh_off[idx] = off;
              sh_len[idx] += sz;
              r.ridx = idx[cfla_pkg::IDX_W-1:0] + 1'b1;
            end else begin
              for (int i = sh_cnt; i > idx; i--) begin
                sh_off[i] = sh_off[i-1];
                sh_len[i] = sh_len[i-1];
              end
              sh_off[idx] = off;
              sh_len[idx] = sz;
              sh_cnt++;
            end
          end
        end
      end
      default: begin
        if (sh_region == 0) r.st = cfla_pkg::ST_BAD_SIZE;
        else begin
          sh_off[0] = '0;
          sh_len[0] = sh_region;
          sh_cnt = 1;
          sh_free = sh_region;
          r.ridx = '0;
        end
      end
    endcase
    best = '0;
    for (int i = 0; i < sh_cnt; i++) if (sh_len[i] > best) best = sh_len[i];
    r.ftot = sh_free;
    r.lfree = best;
    r.cnt = sh_cnt[cfla_pkg::IDX_W-1:0];
    return r;
  endfunction

  // send one transaction; bursts with random gaps, valid held high inside a burst
  int burst_left = 0;
  task automatic send_request(cfla_pkg::kind_t k, int unsigned idx,
                              logic [cfla_pkg::OFF_W-1:0] off,
                              logic [cfla_pkg::OFF_W-1:0] sz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4) * ($urandom_range(0, 2) == 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    entry_index <= idx[cfla_pkg::IDX_W-1:0];
    offset <= off;
    size <= sz;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_request(k, idx, off, sz));
  endtask

  // drain, then write the region register
  task automatic write_region(logic [cfla_pkg::OFF_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    region_size <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_region = val;
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status != e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
        if (result_index != e.ridx) begin
          $error("result_index exp %0d got %0d", e.ridx, result_index); errors++;
        end
        if (alloc_offset != e.aoff) begin
          $error("alloc_offset exp %0h got %0h", e.aoff, alloc_offset); errors++;
        end
        if (free_total != e.ftot) begin
          $error("free_total exp %0h got %0h", e.ftot, free_total); errors++;
        end
        if (largest_free != e.lfree) begin
          $error("largest_free exp %0h got %0h", e.lfree, largest_free); errors++;
        end
        if (entry_count != e.cnt) begin
          $error("entry_count exp %0d got %0d", e.cnt, entry_count); errors++;
        end
      end
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [cfla_pkg::OFF_W-1:0] rand_wide();
    return $urandom();
  endfunction

  task automatic test_errors_before_init();
    send_request(cfla_pkg::K_ALLOC_FRONT, 0, 0, 1);
    send_request(cfla_pkg::K_ALLOC_BACK, 64, 0, 32'hFFFF_FFFF);
    send_request(cfla_pkg::K_FREE, 1, 0, 16);
    send_request(cfla_pkg::K_FREE, 0, 0, 0);
  endtask

  task automatic test_directed_ops();
    send_request(cfla_pkg::K_INIT, 0, 0, 0);
    send_request(cfla_pkg::K_ALLOC_FRONT, 0, 0, 0);
    send_request(cfla_pkg::K_ALLOC_FRONT, 0, 0, 32'h1_0001);
    send_request(cfla_pkg::K_ALLOC_FRONT, 0, 0, 256);
    send_request(cfla_pkg::K_ALLOC_BACK, 0, 0, 256);
    send_request(cfla_pkg::K_FREE, 0, 32'hFFFF_FFFF, 1);
    send_request(cfla_pkg::K_FREE, 1, 32'hFF80, 32'hFFFF_FFFF);
    send_request(cfla_pkg::K_FREE, 0, 0, 512);
    send_request(cfla_pkg::K_FREE, 0, 0, 128);
    send_request(cfla_pkg::K_FREE, 0, 128, 64);
    send_request(cfla_pkg::K_FREE, 1, 32'hFF00, 128);
    send_request(cfla_pkg::K_FREE, 0, 192, 64);
    send_request(cfla_pkg::K_ALLOC_FRONT, 0, 0, sh_len[0]);
    send_request(cfla_pkg::K_FREE, 0, 0, 4);
    send_request(cfla_pkg::K_FREE, 2, 32'hFF80, 32'h80);
    send_request(cfla_pkg::K_FREE, 127, 0, 1);
    send_request(cfla_pkg::K_ALLOC_BACK, 0, 0, sh_len[0]);
  endtask

  task automatic test_full_table();
    write_region(32'd1024);
    send_request(cfla_pkg::K_INIT, 0, 0, 0);
    for (int i = 0; i < 130; i++)
      send_request(cfla_pkg::K_ALLOC_FRONT, 0, 0, 8);
    for (int i = 0; i < 66; i++)
      send_request(cfla_pkg::K_FREE, sh_cnt, i * 16, 4);
    send_request(cfla_pkg::K_FREE, 64, 32'd1016, 4);
  endtask

  task automatic test_region_extremes();
    write_region(32'd0);
    send_request(cfla_pkg::K_INIT, 0, 0, 0);
    send_request(cfla_pkg::K_FREE, 0, 0, 1);
    write_region(32'hFFFF_FFFF);
    send_request(cfla_pkg::K_INIT, 0, 0, 0);
    send_request(cfla_pkg::K_ALLOC_BACK, 0, 0, 32'hFFFF_FFFF);
    send_request(cfla_pkg::K_FREE, 0, 32'hFFFF_FFFE, 1);
    send_request(cfla_pkg::K_FREE, 1, 32'hFFFF_FFFF, 1);
    send_request(cfla_pkg::K_FREE, 0, 0, 32'hFFFF_FFFE);
    write_region(32'd1);
    send_request(cfla_pkg::K_INIT, 0, 0, 0);
    send_request(cfla_pkg::K_ALLOC_FRONT, 0, 0, 1);
    send_request(cfla_pkg::K_FREE, 0, 0, 1);
  endtask

  // mostly coherent requests aimed at live entries and real gaps
  task automatic test_random(int n, logic [cfla_pkg::OFF_W-1:0] region);
    int unsigned idx, pick;
    logic [cfla_pkg::OFF_W-1:0] lo, hi, off, sz;
    write_region(region);
    send_request(cfla_pkg::K_INIT, 0, 0, 0);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        send_request(cfla_pkg::K_INIT, $urandom_range(0, 127), rand_wide(), rand_wide());
      else if (pick < 10)
        send_request(cfla_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 127),
                     rand_wide(), rand_wide());
      else if (pick < 50 && sh_cnt > 0) begin
        idx = $urandom_range(0, sh_cnt - 1);
        sz = ($urandom_range(0, 3) == 0) ? sh_len[idx] :
             $urandom_range(1, (sh_len[idx] > 64) ? 64 : sh_len[idx]);
        send_request(pick[0] ? cfla_pkg::K_ALLOC_BACK : cfla_pkg::K_ALLOC_FRONT, idx, 0, sz);
      end else begin
        idx = $urandom_range(0, sh_cnt);
        lo = (idx > 0) ? sh_off[idx-1] + sh_len[idx-1] : '0;
        hi = (idx < sh_cnt) ? sh_off[idx] : sh_region;
        if (hi <= lo) begin
          send_request(cfla_pkg::K_FREE, idx, lo, 1);
        end else begin
          off = ($urandom_range(0, 2) == 0) ? lo : lo + $urandom_range(0, hi - lo - 1);
          sz = ($urandom_range(0, 2) == 0) ? hi - off :
               $urandom_range(1, ((hi - off) > 64) ? 64 : hi - off);
          if ($urandom_range(0, 15) == 0) sz = sz + 1;
          send_request(cfla_pkg::K_FREE, idx, off, sz);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_errors_before_init();
    test_directed_ops();
    test_full_table();
    test_region_extremes();
    test_random(500, 32'd4096);
    test_random(400, 32'd200);
    test_random(300, 32'hFFFF_FFFF);
    test_random(115, cfla_pkg::REGION_RESET);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== coalescing_free_list_allocator.f =====
hdl/cfla_pkg.sv
hdl/cfla_ram.sv
hdl/coalescing_free_list_allocator.sv
tb/sv/tb_coalescing_free_list_allocator.sv
